[rtl/core/lpfe_pkg.sv]
// lpfe_pkg: shared constants for the lennard-jones pair force and energy core
// register indexes, reset values, fixed-point constants and unit latencies
// no dependencies
package lpfe_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIGMA_LEN  = 3'd0,
		REG_CUT_INNER  = 3'd1,
		REG_CUT_OUTER  = 3'd2,
		REG_BOX_X      = 3'd3,
		REG_BOX_Y      = 3'd4,
		REG_WELL_DEPTH = 3'd5
	} cfg_idx_t;

	localparam logic [31:0] RST_SIGMA_LEN  = 32'd65536;
	localparam logic [31:0] RST_CUT_INNER  = 32'd72090;
	localparam logic [31:0] RST_CUT_OUTER  = 32'd117965;
	localparam logic [31:0] RST_BOX_X      = 32'd1310720;
	localparam logic [31:0] RST_BOX_Y      = 32'd1310720;
	localparam logic [31:0] RST_WELL_DEPTH = 32'd65536;

	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] K12_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 64'd12;
	localparam logic [63:0] OUT_MAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] OUT_NEG = 64'h0000_8000_0000_0000;

	// register counts of the arithmetic units
	localparam int L_MUL = 3;
	localparam int DIV_STEPS = 64;
	localparam int L_DIV = DIV_STEPS + 1;
	localparam int L_SQRT = 32;

endpackage

[rtl/core/lpfe_if.sv]
// lpfe_if: valid/ready channel interfaces for atom pairs and pair results
// depends on nothing
interface lpfe_pair_if;
	logic        valid;
	logic        ready;
	logic [31:0] first_x;
	logic [31:0] first_y;
	logic [31:0] second_x;
	logic [31:0] second_y;

	modport source (output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface lpfe_result_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] force_x;
	logic signed [47:0] force_y;
	logic signed [47:0] pair_energy;
	logic               in_range;
	logic               saturated;

	modport source (output valid, force_x, force_y, pair_energy, in_range, saturated,
		input ready);
	modport sink (input valid, force_x, force_y, pair_energy, in_range, saturated,
		output ready);
endinterface

[rtl/core/lpfe_delay.sv]
// lpfe_delay: stallable shift line that carries side data alongside the units
// no package dependencies
module lpfe_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) tap_s[i] <= '0;
		end else if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) tap_s[i] <= tap_s[i-1];
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

[rtl/core/lpfe_mul64.sv]
// lpfe_mul64: 64x64 multiply, shift right and clip to 64 bits, three stages
// uses lpfe_pkg for the all-ones value
module lpfe_mul64 #(
	parameter int SHIFT = 32
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        sat_i,
	output logic [63:0] p,
	output logic        sat_o
);

	logic [63:0]  pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic         sat_s1, sat_s2, sat_s3;
	logic [127:0] prod_s2;
	logic [63:0]  p_s3;
	logic         ovf;

	assign ovf = |prod_s2[127:64+SHIFT];

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			pp01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			pp10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			pp11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
			sat_s1  <= sat_i;
			prod_s2 <= {64'b0, pp00_s1} + {32'b0, pp01_s1, 32'b0}
				+ {32'b0, pp10_s1, 32'b0} + {pp11_s1, 64'b0};
			sat_s2  <= sat_s1;
			p_s3    <= ovf ? lpfe_pkg::ALL_ONES : prod_s2[63+SHIFT:SHIFT];
			sat_s3  <= sat_s2 | ovf;
		end
	end

	assign p = p_s3;
	assign sat_o = sat_s3;

endmodule

[rtl/core/lpfe_div.sv]
// lpfe_div: floor(num * 2^32 / den) clipped to 64 bits, restoring, one bit a stage
// uses lpfe_pkg for the step count and all-ones value
module lpfe_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic        sat_i,
	output logic [63:0] quo,
	output logic        sat_o
);

	localparam int STEPS = lpfe_pkg::DIV_STEPS;

	logic [63:0] rem_s [STEPS+1];
	logic [63:0] acc_s [STEPS+1];
	logic [63:0] den_s [STEPS+1];
	logic        sat_s [STEPS+1];
	logic        ovf_s [STEPS+1];

	// integer part must stay below 2^32, so the upper word starts as the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {32'b0, num[63:32]};
			acc_s[0] <= {num[31:0], 32'b0};
			den_s[0] <= den;
			sat_s[0] <= sat_i;
			ovf_s[0] <= {32'b0, num[63:32]} >= den;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [64:0] trial;
		logic [64:0] diff;
		logic        ge;

		assign trial = {rem_s[i], acc_s[i][63]};
		assign diff = trial - {1'b0, den_s[i]};
		assign ge = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[63:0] : trial[63:0];
				acc_s[i+1] <= {acc_s[i][62:0], ge};
				den_s[i+1] <= den_s[i];
				sat_s[i+1] <= sat_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign quo = ovf_s[STEPS] ? lpfe_pkg::ALL_ONES : acc_s[STEPS];
	assign sat_o = sat_s[STEPS] | ovf_s[STEPS];

endmodule

[rtl/core/lpfe_isqrt.sv]
// lpfe_isqrt: floor square root of a 64-bit value, one result bit a stage
// uses lpfe_pkg for the stage count
module lpfe_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	localparam int STEPS = lpfe_pkg::L_SQRT;

	logic [63:0] v_s [STEPS];
	logic [63:0] r_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [63:0] BITV = 64'd1 << (62 - 2*i);
		logic [63:0] vprev, rprev, sum;
		logic        ge;

		if (i == 0) begin : g_first
			assign vprev = rad;
			assign rprev = '0;
		end else begin : g_next
			assign vprev = v_s[i-1];
			assign rprev = r_s[i-1];
		end

		assign sum = rprev + BITV;
		assign ge = vprev >= sum;

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i] <= ge ? vprev - sum : vprev;
				r_s[i] <= ge ? (rprev >> 1) + BITV : rprev >> 1;
			end
		end
	end

	assign root = r_s[STEPS-1][31:0];

endmodule

[rtl/core/lj_pair_force_energy_core.sv]
// Lennard-Jones pair force and energy core with a smoothed cutoff, one pair per
// cycle while the result is not stalled; uses lpfe_pkg and the units. A pair
// passes through the 32-step square root and the two 64-step restoring dividers
// in series, and the three-stage multipliers. A stalled result freezes the whole
// pipeline, nothing is dropped. Configuration is written through the plain write
// port, only while the pipeline is empty: a user rule the block does not check.
module lj_pair_force_energy_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [lpfe_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]                    wr_data,
	lpfe_pair_if.sink                      pair,
	lpfe_result_if.source                  result
);

	typedef struct packed {
		logic        neg;
		logic [31:0] mag;
	} axis_t;

	typedef struct packed {
		logic [47:0] val;
		logic        sat;
	} clip_t;

	localparam int L_MUL = lpfe_pkg::L_MUL;
	localparam int T_RS = 4;
	localparam int T_KR = T_RS + lpfe_pkg::L_SQRT + 1 + lpfe_pkg::L_DIV + 2*L_MUL;
	localparam int T_Q6 = T_RS + lpfe_pkg::L_DIV + 3*L_MUL;
	localparam int T_EG = T_KR + 1;
	localparam int T_M = T_EG + 2*L_MUL;
	localparam int T_K = T_M + lpfe_pkg::L_DIV;
	localparam int T_K12 = T_K + 1;
	localparam int T_F = T_K12 + L_MUL;

	function automatic axis_t min_image(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] box);
		logic signed [34:0] d;
		logic [34:0] mag;
		axis_t r;
		d = $signed({3'b0, a}) - $signed({3'b0, b});
		mag = d[34] ? 35'(-d) : 35'(d);
		if ({mag[33:0], 1'b0} > {3'b0, box}) begin
			d = d[34] ? d + $signed({3'b0, box}) : d - $signed({3'b0, box});
		end
		mag = d[34] ? 35'(-d) : 35'(d);
		r.neg = d[34];
		r.mag = mag[31:0];
		return r;
	endfunction

	function automatic clip_t to_out(input logic neg, input logic [63:0] mag);
		logic [63:0] m;
		clip_t c;
		m = mag;
		c.sat = 1'b0;
		if (neg) begin
			if (m > lpfe_pkg::OUT_NEG) begin
				m = lpfe_pkg::OUT_NEG;
				c.sat = 1'b1;
			end
			m = 64'd0 - m;
		end else if (m > lpfe_pkg::OUT_MAX) begin
			m = lpfe_pkg::OUT_MAX;
			c.sat = 1'b1;
		end
		c.val = m[47:0];
		return c;
	endfunction

	// configuration
	logic [31:0] sigma_q, ci_q, co_q, box_x_q, box_y_q, depth_q;
	logic [63:0] sigma2_q, ci2_q, co2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= lpfe_pkg::RST_SIGMA_LEN;
			ci_q    <= lpfe_pkg::RST_CUT_INNER;
			co_q    <= lpfe_pkg::RST_CUT_OUTER;
			box_x_q <= lpfe_pkg::RST_BOX_X;
			box_y_q <= lpfe_pkg::RST_BOX_Y;
			depth_q <= lpfe_pkg::RST_WELL_DEPTH;
		end else if (wr_en) begin
			case (lpfe_pkg::cfg_idx_t'(wr_index))
				lpfe_pkg::REG_SIGMA_LEN:  sigma_q <= wr_data;
				lpfe_pkg::REG_CUT_INNER:  ci_q <= wr_data;
				lpfe_pkg::REG_CUT_OUTER:  co_q <= wr_data;
				lpfe_pkg::REG_BOX_X:      box_x_q <= wr_data;
				lpfe_pkg::REG_BOX_Y:      box_y_q <= wr_data;
				lpfe_pkg::REG_WELL_DEPTH: depth_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sigma2_q <= 64'(sigma_q) * 64'(sigma_q);
		ci2_q    <= 64'(ci_q) * 64'(ci_q);
		co2_q    <= 64'(co_q) * 64'(co_q);
	end

	logic        en;
	logic        res_v_s8;
	logic [31:0] d_span;
	logic        dok;

	assign en = !res_v_s8 || result.ready;
	assign pair.ready = en;
	assign d_span = co_q - ci_q;
	assign dok = co_q > ci_q;

	// front stages: minimum image, squares, distance, range tests
	axis_t       mx, my;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] ax_s1, ay_s1;
	logic        negx_s1, negy_s1;
	logic [63:0] sx_s2, sy_s2;
	logic [64:0] rsq_s3;
	logic [63:0] rsq_s4;
	logic        oor_s4, zero_s4, inner_s4;

	assign mx = min_image(pair.first_x, pair.second_x, box_x_q);
	assign my = min_image(pair.first_y, pair.second_y, box_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= mx.mag;
			ay_s1    <= my.mag;
			negx_s1  <= mx.neg;
			negy_s1  <= my.neg;
			sx_s2    <= 64'(ax_s1) * 64'(ax_s1);
			sy_s2    <= 64'(ay_s1) * 64'(ay_s1);
			rsq_s3   <= 65'(sx_s2) + 65'(sy_s2);
			rsq_s4   <= rsq_s3[63:0];
			oor_s4   <= rsq_s3[64] || (rsq_s3[63:0] > co2_q);
			zero_s4  <= rsq_s3 == 65'd0;
			inner_s4 <= rsq_s3[63:0] <= ci2_q;
		end
	end

	// smoothing factor branch
	logic [31:0] root;
	logic [31:0] tdist_s5;
	logic [63:0] w, wc, u, vsm, kraw, kr;
	logic        wsat, usat, krsat_raw, krsat, inner_d, kr_sel;

	lpfe_isqrt u_sqrt (.clk(clk), .en(en), .rad(rsq_s4), .root(root));

	always_ff @(posedge clk) begin
		if (en) tdist_s5 <= (root > ci_q) ? root - ci_q : 32'd0;
	end

	lpfe_div u_div_w (
		.clk(clk), .en(en), .num({32'b0, tdist_s5}), .den({32'b0, d_span}),
		.sat_i(1'b0), .quo(w), .sat_o(wsat)
	);

	assign wc = (w > lpfe_pkg::ONE_Q32) ? lpfe_pkg::ONE_Q32 : w;

	lpfe_mul64 #(.SHIFT(32)) u_mul_u (
		.clk(clk), .en(en), .a(wc), .b(wc), .sat_i(wsat), .p(u), .sat_o(usat)
	);

	assign vsm = lpfe_pkg::ONE_Q32 - u;

	lpfe_mul64 #(.SHIFT(32)) u_mul_kr (
		.clk(clk), .en(en), .a(vsm), .b(vsm), .sat_i(usat), .p(kraw), .sat_o(krsat_raw)
	);

	lpfe_delay #(.WIDTH(1), .DEPTH(T_KR - T_RS)) u_dly_inner (
		.clk(clk), .arst_n(arst_n), .en(en), .d(inner_s4), .q(inner_d)
	);

	// inside the inner cutoff or with a degenerate band the factor is one
	assign kr_sel = inner_d || !dok;
	assign kr = kr_sel ? lpfe_pkg::ONE_Q32 : kraw;
	assign krsat = kr_sel ? 1'b0 : krsat_raw;

	// powers of sigma^2 / r^2
	logic [63:0] q, q_d, q2, q3, q3_d, q6, q3_a, q6_a;
	logic        qsat, q2sat, q3sat, q6sat, qsat_a;

	lpfe_div u_div_q (
		.clk(clk), .en(en), .num(sigma2_q), .den(rsq_s4), .sat_i(1'b0),
		.quo(q), .sat_o(qsat)
	);

	lpfe_delay #(.WIDTH(64), .DEPTH(L_MUL)) u_dly_q (
		.clk(clk), .arst_n(arst_n), .en(en), .d(q), .q(q_d)
	);

	lpfe_mul64 #(.SHIFT(32)) u_mul_q2 (
		.clk(clk), .en(en), .a(q), .b(q), .sat_i(qsat), .p(q2), .sat_o(q2sat)
	);

	lpfe_mul64 #(.SHIFT(32)) u_mul_q3 (
		.clk(clk), .en(en), .a(q2), .b(q_d), .sat_i(q2sat), .p(q3), .sat_o(q3sat)
	);

	lpfe_delay #(.WIDTH(64), .DEPTH(L_MUL)) u_dly_q3 (
		.clk(clk), .arst_n(arst_n), .en(en), .d(q3), .q(q3_d)
	);

	lpfe_mul64 #(.SHIFT(32)) u_mul_q6 (
		.clk(clk), .en(en), .a(q3), .b(q3), .sat_i(q3sat), .p(q6), .sat_o(q6sat)
	);

	lpfe_delay #(.WIDTH(129), .DEPTH(T_KR - T_Q6)) u_dly_pow (
		.clk(clk), .arst_n(arst_n), .en(en), .d({q3_d, q6, q6sat}),
		.q({q3_a, q6_a, qsat_a})
	);

	// energy and gradient magnitudes
	logic [63:0] emag, gmag, two_q3, extra;
	logic        eneg, gneg, emsat;
	logic [63:0] emag_s6, gmag_s6, kr_s6;
	logic        eneg_s6, gneg_s6, esat_s6;

	assign two_q3 = {q3_a[62:0], 1'b0};
	assign extra = q3_a - q6_a;

	always_comb begin
		emsat = 1'b0;
		eneg = 1'b1;
		if (!q3_a[63] && q6_a >= two_q3) begin
			eneg = 1'b0;
			emag = q6_a - two_q3;
		end else if (!q3_a[63]) begin
			emag = two_q3 - q6_a;
		end else if (q3_a >= q6_a) begin
			if (extra > ~q3_a) begin
				emsat = 1'b1;
				emag = lpfe_pkg::ALL_ONES;
			end else begin
				emag = q3_a + extra;
			end
		end else begin
			emag = q3_a - (q6_a - q3_a);
		end
		gneg = q3_a > q6_a;
		gmag = gneg ? q3_a - q6_a : q6_a - q3_a;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emag_s6 <= emag;
			gmag_s6 <= gmag;
			eneg_s6 <= eneg;
			gneg_s6 <= gneg;
			kr_s6   <= kr;
			esat_s6 <= qsat_a | krsat | emsat;
		end
	end

	// energy chain
	logic [63:0] e1, em, em_f;
	logic        e1sat, emulsat, emsat_f, eneg_f, gneg_f;

	lpfe_mul64 #(.SHIFT(32)) u_mul_e1 (
		.clk(clk), .en(en), .a(emag_s6), .b(kr_s6), .sat_i(esat_s6), .p(e1), .sat_o(e1sat)
	);

	lpfe_mul64 #(.SHIFT(24)) u_mul_e2 (
		.clk(clk), .en(en), .a(e1), .b({32'b0, depth_q}), .sat_i(e1sat),
		.p(em), .sat_o(emulsat)
	);

	lpfe_delay #(.WIDTH(65), .DEPTH(T_F - T_M)) u_dly_e (
		.clk(clk), .arst_n(arst_n), .en(en), .d({em, emulsat}), .q({em_f, emsat_f})
	);

	lpfe_delay #(.WIDTH(2), .DEPTH(T_F - T_EG)) u_dly_sign (
		.clk(clk), .arst_n(arst_n), .en(en), .d({eneg_s6, gneg_s6}), .q({eneg_f, gneg_f})
	);

	// gradient chain
	logic [63:0] g1, gm, rsq_m, k, k12_s7, fx, fy;
	logic        g1sat, gmsat, ksat, ksat_s7, fxsat, fysat;
	logic [31:0] ax_k, ay_k;

	lpfe_mul64 #(.SHIFT(32)) u_mul_g1 (
		.clk(clk), .en(en), .a(gmag_s6), .b(kr_s6), .sat_i(1'b0), .p(g1), .sat_o(g1sat)
	);

	lpfe_mul64 #(.SHIFT(16)) u_mul_g2 (
		.clk(clk), .en(en), .a(g1), .b({32'b0, depth_q}), .sat_i(g1sat),
		.p(gm), .sat_o(gmsat)
	);

	lpfe_delay #(.WIDTH(64), .DEPTH(T_M - T_RS)) u_dly_rsq (
		.clk(clk), .arst_n(arst_n), .en(en), .d(rsq_s4), .q(rsq_m)
	);

	lpfe_div u_div_k (
		.clk(clk), .en(en), .num(gm), .den(rsq_m), .sat_i(gmsat), .quo(k), .sat_o(ksat)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			k12_s7  <= (k > lpfe_pkg::K12_LIM) ? lpfe_pkg::ALL_ONES : (k << 3) + (k << 2);
			ksat_s7 <= ksat || (k > lpfe_pkg::K12_LIM);
		end
	end

	lpfe_delay #(.WIDTH(64), .DEPTH(T_K12 - 1)) u_dly_ax (
		.clk(clk), .arst_n(arst_n), .en(en), .d({ax_s1, ay_s1}), .q({ax_k, ay_k})
	);

	lpfe_mul64 #(.SHIFT(24)) u_mul_fx (
		.clk(clk), .en(en), .a(k12_s7), .b({32'b0, ax_k}), .sat_i(ksat_s7),
		.p(fx), .sat_o(fxsat)
	);

	lpfe_mul64 #(.SHIFT(24)) u_mul_fy (
		.clk(clk), .en(en), .a(k12_s7), .b({32'b0, ay_k}), .sat_i(1'b0),
		.p(fy), .sat_o(fysat)
	);

	// valid and range flags, tapped at the combine stage
	logic v_eg, oor_eg, zero_eg, v_f, oor_f, zero_f, negx_f, negy_f;

	lpfe_delay #(.WIDTH(3), .DEPTH(T_EG - T_RS)) u_dly_flag_a (
		.clk(clk), .arst_n(arst_n), .en(en), .d({v_s4, oor_s4, zero_s4}),
		.q({v_eg, oor_eg, zero_eg})
	);

	lpfe_delay #(.WIDTH(3), .DEPTH(T_F - T_EG)) u_dly_flag_b (
		.clk(clk), .arst_n(arst_n), .en(en), .d({v_eg, oor_eg, zero_eg}),
		.q({v_f, oor_f, zero_f})
	);

	lpfe_delay #(.WIDTH(2), .DEPTH(T_F - 1)) u_dly_neg (
		.clk(clk), .arst_n(arst_n), .en(en), .d({negx_s1, negy_s1}), .q({negx_f, negy_f})
	);

	// output stage
	clip_t       ec, fxc, fyc;
	logic [47:0] fx_o, fy_o, e_o;
	logic        ir_o, sat_o;
	logic [47:0] fx_s8, fy_s8, e_s8;
	logic        ir_s8, sat_s8;

	assign ec = to_out(eneg_f, em_f);
	assign fxc = to_out(gneg_f ^ negx_f, fx);
	assign fyc = to_out(gneg_f ^ negy_f, fy);

	always_comb begin
		fx_o = '0;
		fy_o = '0;
		e_o = '0;
		ir_o = 1'b0;
		sat_o = 1'b0;
		if (oor_f) begin
			ir_o = 1'b0;
		end else if (zero_f) begin
			ir_o = 1'b1;
			sat_o = 1'b1;
			e_o = lpfe_pkg::OUT_MAX[47:0];
		end else begin
			ir_o = 1'b1;
			e_o = ec.val;
			// a zero force magnitude keeps its sign out of the result
			fx_o = (fx == 64'd0) ? 48'd0 : fxc.val;
			fy_o = (fy == 64'd0) ? 48'd0 : fyc.val;
			sat_o = emsat_f | fxsat | fysat | ec.sat
				| ((fx != 64'd0) & fxc.sat) | ((fy != 64'd0) & fyc.sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_s8 <= 1'b0;
		else if (en) res_v_s8 <= v_f;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s8  <= fx_o;
			fy_s8  <= fy_o;
			e_s8   <= e_o;
			ir_s8  <= ir_o;
			sat_s8 <= sat_o;
		end
	end

	assign result.valid = res_v_s8;
	assign result.force_x = $signed(fx_s8);
	assign result.force_y = $signed(fy_s8);
	assign result.pair_energy = $signed(e_s8);
	assign result.in_range = ir_s8;
	assign result.saturated = sat_s8;

	// an out-of-range beat carries nothing but zeros
	ap_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.in_range |->
		result.force_x == 48'sd0 && result.force_y == 48'sd0
		&& result.pair_energy == 48'sd0 && !result.saturated)
		else $error("out-of-range beat with nonzero payload");

	// the smoothing factor never exceeds one
	ap_kr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_eg |-> kr_s6 <= lpfe_pkg::ONE_Q32)
		else $error("smoothing factor above one");

	// with no result held the input side must be open
	ap_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> pair.ready)
		else $error("input blocked with empty output");

endmodule
